@@ design/tmdd_pkg.sv @@
`default_nettype none

package tmdd_pkg;

    // Grid size defaults.
    localparam int GRID_COLS_DEF = 64;
    localparam int GRID_ROWS_DEF = 64;

    // Field widths of the stream items.
    localparam int IN_COL_W  = 6;
    localparam int IN_ROW_W  = 6;
    localparam int CHAN_W    = 16;
    localparam int NUM_CHAN  = 3;
    localparam int WORD_W    = NUM_CHAN * CHAN_W;
    localparam int S_TDATA_W = 64;
    localparam int M_TDATA_W = WORD_W;

    // Configuration port.
    localparam int GAIN_W    = 16;
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_DIFFUSION = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_RETENTION = 1'b1;
    localparam logic [GAIN_W-1:0] DIFFUSION_RESET = 16'd32768;
    localparam logic [GAIN_W-1:0] RETENTION_RESET = 16'd58982;

    // Item kinds carried on tuser.
    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_READ  = 1'b1;

    // Arithmetic widths. The sum of nine channels fits in 20 bits.
    localparam int BLUR_AREA    = 9;
    localparam int SUM_W        = 20;
    localparam int PROD1_W      = SUM_W + GAIN_W;
    localparam int RECIP_W      = 16;
    localparam int RECIP9_SHIFT = 19;
    localparam logic [RECIP_W-1:0] RECIP9 = RECIP_W'((1 << RECIP9_SHIFT) / BLUR_AREA);
    localparam int QP_W         = SUM_W + RECIP_W;
    localparam int Q_W          = QP_W - RECIP9_SHIFT;
    localparam int REM_W        = SUM_W + 1;
    localparam int T_W          = Q_W + 1;
    localparam int PROD2_W      = T_W + GAIN_W;

    // Neighbour offset along one axis.
    typedef enum logic [1:0] {
        OFF_MINUS = 2'd0,
        OFF_ZERO  = 2'd1,
        OFF_PLUS  = 2'd2
    } offset_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    clr_en;
        logic    wr_en;
        logic    load;
        logic    rd_en;
        offset_t dc;
        offset_t dr;
        logic    acc_en;
        logic    ctr_cap;
        logic    mul1;
        logic    div;
        logic    add;
        logic    mul2;
        logic    out_load;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clr_last;
    } dp_status_t;

endpackage

`default_nettype wire

@@ design/tmdd_ram.sv @@
`default_nettype none

module tmdd_ram #(
    parameter int WIDTH = tmdd_pkg::WORD_W,
    parameter int DEPTH = tmdd_pkg::GRID_COLS_DEF * tmdd_pkg::GRID_ROWS_DEF
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem_reg[addr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

@@ design/tmdd_ctrl.sv @@
`default_nettype none

module tmdd_ctrl (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic                   s_func,
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    input  wire tmdd_pkg::dp_status_t   status,
    output tmdd_pkg::dp_cmd_t           cmd
);

    import tmdd_pkg::*;

    typedef enum logic [8:0] {
        ST_CLEAR = 9'b000000001,
        ST_IDLE  = 9'b000000010,
        ST_READ  = 9'b000000100,
        ST_DRAIN = 9'b000001000,
        ST_MUL1  = 9'b000010000,
        ST_DIV   = 9'b000100000,
        ST_ADD   = 9'b001000000,
        ST_MUL2  = 9'b010000000,
        ST_OUT   = 9'b100000000
    } state_t;

    state_t  state_reg, state_next;
    offset_t dc_reg, dc_next;
    offset_t dr_reg, dr_next;
    logic    acc_pend_reg, acc_pend_next;
    logic    ctr_pend_reg, ctr_pend_next;
    logic    mvalid_reg, mvalid_next;
    logic    accept;
    logic    out_load;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_load = (state_reg == ST_OUT) && (!mvalid_reg || m_tready);
    assign m_tvalid = mvalid_reg;

    always_comb begin
        state_next    = state_reg;
        dc_next       = dc_reg;
        dr_next       = dr_reg;
        // Read data returns in the cycle after its address, so accumulation lags.
        acc_pend_next = (state_reg == ST_READ);
        ctr_pend_next = (state_reg == ST_READ) && (dc_reg == OFF_ZERO) && (dr_reg == OFF_ZERO);

        unique case (state_reg)
            ST_CLEAR: begin
                if (status.clr_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept && (s_func == FUNC_READ)) begin
                    state_next = ST_READ;
                    dc_next    = OFF_MINUS;
                    dr_next    = OFF_MINUS;
                end
            end
            ST_READ: begin
                if (dc_reg == OFF_PLUS) begin
                    dc_next = OFF_MINUS;
                    if (dr_reg == OFF_PLUS) begin
                        state_next = ST_DRAIN;
                    end else if (dr_reg == OFF_MINUS) begin
                        dr_next = OFF_ZERO;
                    end else begin
                        dr_next = OFF_PLUS;
                    end
                end else if (dc_reg == OFF_MINUS) begin
                    dc_next = OFF_ZERO;
                end else begin
                    dc_next = OFF_PLUS;
                end
            end
            ST_DRAIN: state_next = ST_MUL1;
            ST_MUL1:  state_next = ST_DIV;
            ST_DIV:   state_next = ST_ADD;
            ST_ADD:   state_next = ST_MUL2;
            ST_MUL2:  state_next = ST_OUT;
            ST_OUT: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_CLEAR;
        endcase

        if (out_load) begin
            mvalid_next = 1'b1;
        end else if (m_tready) begin
            mvalid_next = 1'b0;
        end else begin
            mvalid_next = mvalid_reg;
        end
    end

    always_comb begin
        cmd          = '0;
        cmd.clr_en   = (state_reg == ST_CLEAR);
        cmd.wr_en    = accept && (s_func == FUNC_WRITE);
        cmd.load     = accept && (s_func == FUNC_READ);
        cmd.rd_en    = (state_reg == ST_READ);
        cmd.dc       = dc_reg;
        cmd.dr       = dr_reg;
        cmd.acc_en   = acc_pend_reg;
        cmd.ctr_cap  = ctr_pend_reg;
        cmd.mul1     = (state_reg == ST_MUL1);
        cmd.div      = (state_reg == ST_DIV);
        cmd.add      = (state_reg == ST_ADD);
        cmd.mul2     = (state_reg == ST_MUL2);
        cmd.out_load = out_load;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            dc_reg       <= OFF_MINUS;
            dr_reg       <= OFF_MINUS;
            acc_pend_reg <= 1'b0;
            ctr_pend_reg <= 1'b0;
            mvalid_reg   <= 1'b0;
        end else begin
            state_reg    <= state_next;
            dc_reg       <= dc_next;
            dr_reg       <= dr_next;
            acc_pend_reg <= acc_pend_next;
            ctr_pend_reg <= ctr_pend_next;
            mvalid_reg   <= mvalid_next;
        end
    end

endmodule

`default_nettype wire

@@ design/tmdd_dp.sv @@
`default_nettype none

module tmdd_dp #(
    parameter int GRID_COLS = tmdd_pkg::GRID_COLS_DEF,
    parameter int GRID_ROWS = tmdd_pkg::GRID_ROWS_DEF
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire tmdd_pkg::dp_cmd_t                  cmd,
    output tmdd_pkg::dp_status_t                    status,
    input  wire logic [tmdd_pkg::S_TDATA_W-1:0]     s_tdata,
    input  wire logic                               cfg_we,
    input  wire logic [tmdd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [tmdd_pkg::GAIN_W-1:0]        cfg_wdata,
    output logic      [tmdd_pkg::M_TDATA_W-1:0]     m_tdata
);

    import tmdd_pkg::*;

    localparam int COL_W       = $clog2(GRID_COLS);
    localparam int ROW_W       = $clog2(GRID_ROWS);
    localparam int ADDR_W      = COL_W + ROW_W;
    localparam int DEPTH       = 1 << ADDR_W;
    localparam int IN_COL_SPAN = 1 << IN_COL_W;
    localparam int IN_ROW_SPAN = 1 << IN_ROW_W;
    localparam logic [COL_W-1:0] COL_MAX = COL_W'(GRID_COLS - 1);
    localparam logic [ROW_W-1:0] ROW_MAX = ROW_W'(GRID_ROWS - 1);

    // Reduction of the input coordinates onto the grid, as constant tables.
    logic [COL_W-1:0] col_tab [IN_COL_SPAN];
    logic [ROW_W-1:0] row_tab [IN_ROW_SPAN];

    for (genvar gi = 0; gi < IN_COL_SPAN; gi++) begin : g_col_tab
        assign col_tab[gi] = COL_W'(gi % GRID_COLS);
    end
    for (genvar gj = 0; gj < IN_ROW_SPAN; gj++) begin : g_row_tab
        assign row_tab[gj] = ROW_W'(gj % GRID_ROWS);
    end

    logic [IN_COL_W-1:0] in_col;
    logic [IN_ROW_W-1:0] in_row;
    logic [WORD_W-1:0]   in_word;
    logic [COL_W-1:0]    in_col_m;
    logic [ROW_W-1:0]    in_row_m;

    assign in_col   = s_tdata[IN_COL_W-1:0];
    assign in_row   = s_tdata[IN_COL_W +: IN_ROW_W];
    assign in_word  = s_tdata[IN_COL_W + IN_ROW_W +: WORD_W];
    assign in_col_m = col_tab[in_col];
    assign in_row_m = row_tab[in_row];

    logic [COL_W-1:0]  col_reg;
    logic [ROW_W-1:0]  row_reg;
    logic [ADDR_W-1:0] clr_cnt_reg;
    logic [GAIN_W-1:0] dg_reg;
    logic [GAIN_W-1:0] rg_reg;

    logic [COL_W-1:0]  nb_col;
    logic [ROW_W-1:0]  nb_row;
    logic [ADDR_W-1:0] ram_addr;
    logic [WORD_W-1:0] ram_wdata;
    logic [WORD_W-1:0] ram_rdata;
    logic              ram_we;

    // Wrap-around neighbour of the cell being read.
    always_comb begin
        unique case (cmd.dc)
            OFF_MINUS: nb_col = (col_reg == '0) ? COL_MAX : col_reg - COL_W'(1);
            OFF_PLUS:  nb_col = (col_reg == COL_MAX) ? '0 : col_reg + COL_W'(1);
            default:   nb_col = col_reg;
        endcase
        unique case (cmd.dr)
            OFF_MINUS: nb_row = (row_reg == '0) ? ROW_MAX : row_reg - ROW_W'(1);
            OFF_PLUS:  nb_row = (row_reg == ROW_MAX) ? '0 : row_reg + ROW_W'(1);
            default:   nb_row = row_reg;
        endcase
    end

    always_comb begin
        priority if (cmd.clr_en) begin
            ram_addr  = clr_cnt_reg;
            ram_wdata = '0;
        end else if (cmd.wr_en) begin
            ram_addr  = {in_row_m, in_col_m};
            ram_wdata = in_word;
        end else begin
            ram_addr  = {nb_row, nb_col};
            ram_wdata = in_word;
        end
    end

    assign ram_we          = cmd.clr_en || cmd.wr_en;
    assign status.clr_last = (clr_cnt_reg == ADDR_W'(DEPTH - 1));

    tmdd_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (aclk),
        .we    (ram_we),
        .re    (cmd.rd_en),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg <= '0;
            dg_reg      <= DIFFUSION_RESET;
            rg_reg      <= RETENTION_RESET;
        end else begin
            if (cmd.clr_en) begin
                clr_cnt_reg <= clr_cnt_reg + ADDR_W'(1);
            end
            if (cfg_we && (cfg_index == CFG_DIFFUSION)) begin
                dg_reg <= cfg_wdata;
            end
            if (cfg_we && (cfg_index == CFG_RETENTION)) begin
                rg_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            col_reg <= in_col_m;
            row_reg <= in_row_m;
        end
    end

    // Per-channel arithmetic, three lanes side by side.
    logic [SUM_W-1:0]   sum_reg   [NUM_CHAN];
    logic [CHAN_W-1:0]  ctr_reg   [NUM_CHAN];
    logic [PROD1_W-1:0] prod1_reg [NUM_CHAN];
    logic [SUM_W-1:0]   x_reg     [NUM_CHAN];
    logic [QP_W-1:0]    qp_reg    [NUM_CHAN];
    logic [T_W-1:0]     t_reg     [NUM_CHAN];
    logic [PROD2_W-1:0] prod2_reg [NUM_CHAN];
    logic [WORD_W-1:0]  out_reg;
    logic [T_W-1:0]     t_next    [NUM_CHAN];
    logic [CHAN_W-1:0]  sat       [NUM_CHAN];

    // The reciprocal of nine is rounded down, so the first quotient is exact or one
    // short; a single compare against the remainder corrects it.
    always_comb begin
        logic [Q_W-1:0]     q0;
        logic [REM_W-1:0]   rem;
        logic [Q_W-1:0]     d;
        logic [T_W-GAIN_W+CHAN_W-1:0] n;
        for (int ch = 0; ch < NUM_CHAN; ch++) begin
            q0  = qp_reg[ch][QP_W-1:RECIP9_SHIFT];
            rem = REM_W'(x_reg[ch]) - (REM_W'(q0) << 3) - REM_W'(q0);
            d   = (rem >= REM_W'(BLUR_AREA)) ? q0 + Q_W'(1) : q0;
            t_next[ch] = T_W'(d) + T_W'(ctr_reg[ch]);
            n   = prod2_reg[ch][PROD2_W-1:GAIN_W];
            sat[ch] = (n[T_W-GAIN_W+CHAN_W-1:CHAN_W] != '0) ? '1 : n[CHAN_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        for (int ch = 0; ch < NUM_CHAN; ch++) begin
            if (cmd.load) begin
                sum_reg[ch] <= '0;
            end else if (cmd.acc_en) begin
                sum_reg[ch] <= sum_reg[ch] + SUM_W'(ram_rdata[ch*CHAN_W +: CHAN_W]);
            end
            if (cmd.ctr_cap) begin
                ctr_reg[ch] <= ram_rdata[ch*CHAN_W +: CHAN_W];
            end
            if (cmd.mul1) begin
                prod1_reg[ch] <= PROD1_W'(sum_reg[ch]) * PROD1_W'(dg_reg);
            end
            if (cmd.div) begin
                x_reg[ch]  <= prod1_reg[ch][PROD1_W-1:GAIN_W];
                qp_reg[ch] <= QP_W'(prod1_reg[ch][PROD1_W-1:GAIN_W]) * QP_W'(RECIP9);
            end
            if (cmd.add) begin
                t_reg[ch] <= t_next[ch];
            end
            if (cmd.mul2) begin
                prod2_reg[ch] <= PROD2_W'(t_reg[ch]) * PROD2_W'(rg_reg);
            end
            if (cmd.out_load) begin
                out_reg[ch*CHAN_W +: CHAN_W] <= sat[ch];
            end
        end
    end

    assign m_tdata = out_reg;

endmodule

`default_nettype wire

@@ design/trail_map_diffuse_decay.sv @@
// Trail map diffuse-and-decay unit.
// The grid of three-channel trail values lives in one single-port memory.
// Input stream: s_tuser selects a write (store red, green and blue at a cell)
// or a read (return the cell's blurred and decayed value). A write gives no
// result; writes can follow one another every cycle while the unit is idle.
// A read fetches the nine wrap-around neighbours one per cycle through the
// memory port, then runs two multiplies and a divide by nine in five more
// steps (drain, multiply, divide, add, multiply); the result then goes into the
// output register, and the next item is taken in the cycle after that load.
// Gains must be written on the cfg port only whilst idle; the unit does not check it.
// After reset the unit sweeps the memory to zero, one cell per cycle, over all
// 2**(clog2(GRID_COLS) + clog2(GRID_ROWS)) cells (4096 for a 64 x 64 grid);
// s_tready stays low during that sweep.
// If the receiver stalls, the result waits in the output register; the unit
// still takes writes and starts the next read, which holds at its last step
// until the output register is free.
`default_nettype none

module trail_map_diffuse_decay #(
    parameter int GRID_COLS = tmdd_pkg::GRID_COLS_DEF,
    parameter int GRID_ROWS = tmdd_pkg::GRID_ROWS_DEF
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    // col [5:0], row [11:6], red_in [27:12], green_in [43:28], blue_in [59:44], zero pad
    input  wire logic [tmdd_pkg::S_TDATA_W-1:0]     s_tdata,
    // func
    input  wire logic                               s_tuser,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    // red_out [15:0], green_out [31:16], blue_out [47:32]
    output logic      [tmdd_pkg::M_TDATA_W-1:0]     m_tdata,
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    input  wire logic                               cfg_we,
    input  wire logic [tmdd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [tmdd_pkg::GAIN_W-1:0]        cfg_wdata
);

    import tmdd_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    tmdd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_func   (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    tmdd_dp #(
        .GRID_COLS (GRID_COLS),
        .GRID_ROWS (GRID_ROWS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .s_tdata   (s_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .m_tdata   (m_tdata)
    );

    // A read occupies the memory port, so no further transaction is taken next cycle.
    a_read_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && (s_tuser == FUNC_READ)) |=> !s_tready)
        else $error("input taken while a read is in progress");

    // A write never produces a result of its own.
    a_write_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && (s_tuser == FUNC_WRITE) && !m_tvalid) |=> !m_tvalid)
        else $error("result appeared after a write");

    // The memory sweep after reset keeps the input closed.
    a_clear_closed: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(!aresetn) |-> !s_tready)
        else $error("input open before the memory sweep");

endmodule

`default_nettype wire
